// ----- src/mpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpc_pkg - shared definitions for the motor position compensator
// Fixed-point formats, filter coefficients, register indexes and the small
// structures passed between the compensator modules.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COUNT_WIDTH = 16;

  localparam int COEF_FRAC = 24;
  localparam int COEF_W    = 28;
  localparam int DATA_W    = 32;
  localparam int VOLT_W    = 21;
  localparam int LIM_W     = 20;
  localparam int PERIOD_W  = 16;
  localparam int TERM_W    = COEF_W + DATA_W;
  localparam int SUM_W     = TERM_W + 2;
  localparam int ROUND_W   = SUM_W - COEF_FRAC;

  localparam int DIGIT_W     = 4;
  localparam int DIGITS      = DATA_W / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(DIGITS);

  localparam int NUM_TERMS  = 7;
  localparam int TERM_IDX_W = $clog2(NUM_TERMS);

  localparam int STEP_DIVISOR = 144;
  localparam int STEP_BIAS    = STEP_DIVISOR / 2;
  localparam int STEP_NUM_W   = COUNT_WIDTH + FRAC_BITS;
  localparam int STEP_REM_W   = $clog2(STEP_DIVISOR);
  localparam int STEP_CNT_W   = $clog2(STEP_NUM_W);

  localparam int V_MAX       = 1048575;
  localparam int V_BIAS      = 12 * (2 ** FRAC_BITS);
  localparam int BIAS_W      = VOLT_W + 1;
  localparam int PROD_W      = BIAS_W + PERIOD_W + 1;
  localparam int PWM_SHIFT   = FRAC_BITS + 3;
  localparam int QUO_W       = PROD_W - 1 - PWM_SHIFT;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = 20;
  localparam int RECIP       = (2 ** RECIP_SHIFT + 2) / 3;
  localparam int SCALE_W     = QUO_W + RECIP_W;

  localparam logic signed [COEF_W-1:0] K_ERR0  = 28'sd60767076;
  localparam logic signed [COEF_W-1:0] K_ERR1  = -28'sd82476794;
  localparam logic signed [COEF_W-1:0] K_ERR2  = 28'sd49727668;
  localparam logic signed [COEF_W-1:0] K_ERR3  = 28'sd11235702;
  localparam logic signed [COEF_W-1:0] K_OUT01 = 28'sd140119;
  localparam logic signed [COEF_W-1:0] K_OUT2  = -28'sd249477;
  localparam logic signed [COEF_W-1:0] K_OUT3  = -28'sd9805;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_ANGLE    = 3'd0,
    REG_DRIVE_LIMIT     = 3'd1,
    REG_DEAD_THRESHOLD  = 3'd2,
    REG_FRICTION_OFFSET = 3'd3,
    REG_PWM_PERIOD      = 3'd4
  } cfg_reg_t;

  typedef enum logic [TERM_IDX_W-1:0] {
    TERM_ERR1  = 3'd0,
    TERM_ERR2  = 3'd1,
    TERM_ERR3  = 3'd2,
    TERM_OUT1  = 3'd3,
    TERM_OUT2  = 3'd4,
    TERM_OUT3  = 3'd5,
    TERM_ERR0  = 3'd6
  } term_t;

  typedef struct packed {
    logic ready;
    logic idle;
  } mac_status_t;

  typedef struct packed {
    logic [LIM_W-1:0]    drive_limit;
    logic [LIM_W-1:0]    dead_threshold;
    logic [LIM_W-1:0]    friction_offset;
    logic [PERIOD_W-1:0] pwm_period;
  } shaper_cfg_t;

  function automatic logic signed [COEF_W-1:0] term_coef(input logic [TERM_IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] k;
    case (idx)
      TERM_ERR1: k = K_ERR1;
      TERM_ERR2: k = K_ERR2;
      TERM_ERR3: k = K_ERR3;
      TERM_OUT1: k = K_OUT01;
      TERM_OUT2: k = K_OUT2;
      TERM_OUT3: k = K_OUT3;
      TERM_ERR0: k = K_ERR0;
      default:   k = '0;
    endcase
    return k;
  endfunction

endpackage

// ----- src/motor_position_compensator.sv -----
// ----------------------------------------------------------------------------
// motor_position_compensator - digit-serial position compensator
// Encoder angle tracking, fixed difference-equation compensator, voltage
// clamp with friction compensation and PWM compare output.
// ----------------------------------------------------------------------------
// One input transfer per control tick yields one result transfer. In a tick, the
// seven filter products pass through one digit-serial multiply-accumulate
// unit one after another, followed by the shaping pipeline, while the angle
// step divider (one bit per cycle) runs alongside the first products. A new
// tick is taken as soon as the previous result sits in the output register,
// even if that result has not yet been taken. Configuration writes are taken
// at any time but should only be made between ticks.
// ----------------------------------------------------------------------------
module motor_position_compensator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,   // [15:0] count_delta
  input  logic [0:0]                        s_tuser,   // [0] enabled
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] compare_value, [36:16] drive_voltage, [68:37] angle_now,
  // [100:69] angle_error, [103:101] zero
  output logic [103:0]                      m_tdata,
  input  logic                              cfg_we,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int OutBits = mpc_pkg::PERIOD_W + mpc_pkg::VOLT_W + 2 * mpc_pkg::DATA_W;
  localparam int PadBits = 104 - OutBits;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_POST  = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  state_t state;

  logic signed [mpc_pkg::DATA_W-1:0]    target_angle;
  mpc_pkg::shaper_cfg_t                 shp_cfg;

  logic signed [mpc_pkg::DATA_W-1:0]    angle;
  logic signed [mpc_pkg::DATA_W-1:0]    angle_next;
  logic signed [mpc_pkg::DATA_W-1:0]    err;
  logic signed [mpc_pkg::DATA_W-1:0]    err_next;
  logic signed [mpc_pkg::DATA_W:0]      err_diff;
  logic signed [mpc_pkg::DATA_W-1:0]    setpoint;
  logic signed [mpc_pkg::DATA_W-1:0]    err_hist [3];
  logic signed [mpc_pkg::VOLT_W-1:0]    volt_hist [3];
  logic                                 en;
  logic                                 err_go;
  logic                                 err_ok;
  logic [mpc_pkg::TERM_IDX_W-1:0]       term_idx;

  logic                                 accept;
  logic                                 out_free;

  logic                                 div_done;
  logic [mpc_pkg::STEP_NUM_W-1:0]       div_quot;
  logic                                 div_neg;

  logic                                 mac_ld;
  logic [mpc_pkg::DATA_W-1:0]           mac_op;
  logic signed [mpc_pkg::COEF_W-1:0]    mac_coef;
  mpc_pkg::mac_status_t                 mac_st;
  logic signed [mpc_pkg::SUM_W-1:0]     mac_acc;

  logic                                 shp_start;
  logic                                 shp_done;
  logic signed [mpc_pkg::VOLT_W-1:0]    shp_volt;
  logic [mpc_pkg::PERIOD_W-1:0]         shp_cmp;

  assign s_tready  = state == ST_IDLE;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign shp_start = (state == ST_DRAIN) && mac_st.idle;
  assign mac_ld    = (state == ST_RUN) && mac_st.ready
                  && ((term_idx != mpc_pkg::TERM_ERR0) || err_ok);
  assign mac_coef  = mpc_pkg::term_coef(term_idx);

  assign angle_next = div_neg ? angle - mpc_pkg::DATA_W'(div_quot)
                              : angle + mpc_pkg::DATA_W'(div_quot);
  assign setpoint   = en ? target_angle : '0;
  assign err_diff   = (mpc_pkg::DATA_W + 1)'(setpoint) - (mpc_pkg::DATA_W + 1)'(angle);

  always_comb begin
    if (err_diff[mpc_pkg::DATA_W] != err_diff[mpc_pkg::DATA_W-1]) begin
      err_next = err_diff[mpc_pkg::DATA_W] ? {1'b1, {(mpc_pkg::DATA_W-1){1'b0}}}
                                           : {1'b0, {(mpc_pkg::DATA_W-1){1'b1}}};
    end else begin
      err_next = err_diff[mpc_pkg::DATA_W-1:0];
    end
  end

  always_comb begin
    case (term_idx)
      mpc_pkg::TERM_ERR1: mac_op = en ? err_hist[0] : '0;
      mpc_pkg::TERM_ERR2: mac_op = en ? err_hist[1] : '0;
      mpc_pkg::TERM_ERR3: mac_op = en ? err_hist[2] : '0;
      mpc_pkg::TERM_OUT1: mac_op = en ? mpc_pkg::DATA_W'(volt_hist[0]) : '0;
      mpc_pkg::TERM_OUT2: mac_op = en ? mpc_pkg::DATA_W'(volt_hist[1]) : '0;
      mpc_pkg::TERM_OUT3: mac_op = en ? mpc_pkg::DATA_W'(volt_hist[2]) : '0;
      mpc_pkg::TERM_ERR0: mac_op = err;
      default:            mac_op = '0;
    endcase
  end

  mpc_step_div u_step_div (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .count_delta (s_tdata[mpc_pkg::COUNT_WIDTH-1:0]),
    .done        (div_done),
    .quotient    (div_quot),
    .step_neg    (div_neg)
  );

  mpc_digit_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .clr     (accept),
    .ld      (mac_ld),
    .operand (mac_op),
    .coef    (mac_coef),
    .status  (mac_st),
    .acc     (mac_acc)
  );

  mpc_drive_shaper u_shaper (
    .clk           (clk),
    .rst           (rst),
    .start         (shp_start),
    .sum           (mac_acc),
    .cfg           (shp_cfg),
    .done          (shp_done),
    .drive_voltage (shp_volt),
    .compare_value (shp_cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                   <= ST_IDLE;
      m_tvalid                <= 1'b0;
      target_angle            <= 32'sd5898240;
      shp_cfg.drive_limit     <= 20'd786432;
      shp_cfg.dead_threshold  <= 20'd137626;
      shp_cfg.friction_offset <= 20'd117965;
      shp_cfg.pwm_period      <= 16'd8999;
      angle                   <= '0;
      err_go                  <= 1'b0;
      err_ok                  <= 1'b0;
      term_idx                <= '0;
      en                      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        err_hist[i]  <= '0;
        volt_hist[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mpc_pkg::REG_TARGET_ANGLE:    target_angle <= cfg_data;
          mpc_pkg::REG_DRIVE_LIMIT:     shp_cfg.drive_limit <= cfg_data[mpc_pkg::LIM_W-1:0];
          mpc_pkg::REG_DEAD_THRESHOLD:  shp_cfg.dead_threshold <= cfg_data[mpc_pkg::LIM_W-1:0];
          mpc_pkg::REG_FRICTION_OFFSET: shp_cfg.friction_offset <= cfg_data[mpc_pkg::LIM_W-1:0];
          mpc_pkg::REG_PWM_PERIOD:      shp_cfg.pwm_period <= cfg_data[mpc_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      err_go <= div_done;
      if (div_done) begin
        angle <= angle_next;
      end
      if (err_go) begin
        err    <= err_next;
        err_ok <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            en       <= s_tuser[0];
            term_idx <= '0;
            err_ok   <= 1'b0;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (mac_ld) begin
            term_idx <= term_idx + 1'b1;
            if (term_idx == mpc_pkg::TERM_ERR0) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (mac_st.idle) begin
            state <= ST_POST;
          end
        end
        ST_POST: begin
          if (shp_done) begin
            err_hist[0]  <= err;
            volt_hist[0] <= shp_volt;
            err_hist[1]  <= en ? err_hist[0] : '0;
            err_hist[2]  <= en ? err_hist[1] : '0;
            volt_hist[1] <= en ? volt_hist[0] : '0;
            volt_hist[2] <= en ? volt_hist[1] : '0;
            if (out_free) begin
              m_tdata  <= {{PadBits{1'b0}}, err, angle, shp_volt, shp_cmp};
              m_tvalid <= 1'b1;
              state    <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (m_tready) begin
            m_tdata  <= {{PadBits{1'b0}}, err, angle, shp_volt, shp_cmp};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/mpc_step_div.sv -----
// ----------------------------------------------------------------------------
// mpc_step_div - bit-serial angle step divider
// Divides the scaled encoder count magnitude by the counts-per-degree
// constant with round-to-nearest, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module mpc_step_div (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [mpc_pkg::COUNT_WIDTH-1:0]  count_delta,
  output logic                                    done,
  output logic        [mpc_pkg::STEP_NUM_W-1:0]   quotient,
  output logic                                    step_neg
);

  logic                               busy;
  logic [mpc_pkg::STEP_CNT_W-1:0]     bit_cnt;
  logic [mpc_pkg::STEP_REM_W-1:0]     rem;
  logic [mpc_pkg::STEP_NUM_W-1:0]     num;
  logic [mpc_pkg::COUNT_WIDTH-1:0]    mag;
  logic [mpc_pkg::STEP_NUM_W-1:0]     num_init;
  logic [mpc_pkg::STEP_REM_W:0]       trial;
  logic                               fits;

  assign mag      = count_delta[mpc_pkg::COUNT_WIDTH-1] ? (~count_delta + 1'b1) : count_delta;
  assign num_init = {mag, {mpc_pkg::FRAC_BITS{1'b0}}}
                  + mpc_pkg::STEP_NUM_W'(mpc_pkg::STEP_BIAS);
  assign trial    = {rem, num[mpc_pkg::STEP_NUM_W-1]};
  assign fits     = trial >= (mpc_pkg::STEP_REM_W + 1)'(mpc_pkg::STEP_DIVISOR);
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        bit_cnt  <= '0;
        rem      <= '0;
        num      <= num_init;
        step_neg <= ~count_delta[mpc_pkg::COUNT_WIDTH-1];
      end else if (busy) begin
        if (fits) begin
          rem <= mpc_pkg::STEP_REM_W'(trial - (mpc_pkg::STEP_REM_W + 1)'(mpc_pkg::STEP_DIVISOR));
        end else begin
          rem <= trial[mpc_pkg::STEP_REM_W-1:0];
        end
        num     <= {num[mpc_pkg::STEP_NUM_W-2:0], fits};
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == mpc_pkg::STEP_CNT_W'(mpc_pkg::STEP_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/mpc_digit_mac.sv -----
// ----------------------------------------------------------------------------
// mpc_digit_mac - digit-serial multiply-accumulate unit
// Multiplies a signed operand by a filter coefficient one four-bit digit per
// cycle, most significant digit first, and adds each finished term to the sum.
// ----------------------------------------------------------------------------
module mpc_digit_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  clr,
  input  logic                                  ld,
  input  logic        [mpc_pkg::DATA_W-1:0]     operand,
  input  logic signed [mpc_pkg::COEF_W-1:0]     coef,
  output mpc_pkg::mac_status_t                  status,
  output logic signed [mpc_pkg::SUM_W-1:0]      acc
);

  logic                                 active;
  logic                                 pend;
  logic [mpc_pkg::DIGIT_CNT_W-1:0]      dig_cnt;
  logic [mpc_pkg::DATA_W-1:0]           x;
  logic signed [mpc_pkg::COEF_W-1:0]    k;
  logic signed [mpc_pkg::TERM_W-1:0]    term;
  logic signed [mpc_pkg::DIGIT_W:0]     digit;
  logic signed [mpc_pkg::COEF_W+mpc_pkg::DIGIT_W:0] kd;
  logic signed [mpc_pkg::TERM_W-1:0]    term_next;
  logic                                 first;
  logic                                 last;

  assign first = dig_cnt == '0;
  assign last  = active && (dig_cnt == mpc_pkg::DIGIT_CNT_W'(mpc_pkg::DIGITS - 1));
  assign digit = {first ? x[mpc_pkg::DATA_W-1] : 1'b0, x[mpc_pkg::DATA_W-1 -: mpc_pkg::DIGIT_W]};
  assign kd    = (mpc_pkg::COEF_W + mpc_pkg::DIGIT_W + 1)'(k)
               * (mpc_pkg::COEF_W + mpc_pkg::DIGIT_W + 1)'(digit);
  assign term_next = (first ? '0 : (term <<< mpc_pkg::DIGIT_W)) + mpc_pkg::TERM_W'(kd);

  assign status.ready = !active || last;
  assign status.idle  = !active && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      pend    <= 1'b0;
      dig_cnt <= '0;
    end else begin
      pend <= last;
      if (ld) begin
        active  <= 1'b1;
        dig_cnt <= '0;
        x       <= operand;
        k       <= coef;
      end else if (active) begin
        dig_cnt <= dig_cnt + 1'b1;
        x       <= x << mpc_pkg::DIGIT_W;
        if (last) begin
          active <= 1'b0;
        end
      end
      if (active) begin
        term <= term_next;
      end
      if (clr) begin
        acc <= '0;
      end else if (pend) begin
        acc <= acc + mpc_pkg::SUM_W'(term);
      end
    end
  end

endmodule

// ----- src/mpc_drive_shaper.sv -----
// ----------------------------------------------------------------------------
// mpc_drive_shaper - drive voltage shaping and PWM scaling
// Rounds the filter sum, applies the voltage clamp, the friction offset and
// saturation, then scales the voltage to a PWM compare value in five stages.
// ----------------------------------------------------------------------------
module mpc_drive_shaper (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [mpc_pkg::SUM_W-1:0]      sum,
  input  mpc_pkg::shaper_cfg_t                  cfg,
  output logic                                  done,
  output logic signed [mpc_pkg::VOLT_W-1:0]     drive_voltage,
  output logic        [mpc_pkg::PERIOD_W-1:0]   compare_value
);

  logic [4:0]                               stage_vld;
  logic signed [mpc_pkg::SUM_W-1:0]         sum_rnd;
  logic signed [mpc_pkg::ROUND_W-1:0]       u_r;
  logic                                     u_neg;
  logic [mpc_pkg::ROUND_W-1:0]              u_mag;
  logic signed [mpc_pkg::BIAS_W-1:0]        u_low;
  logic signed [mpc_pkg::BIAS_W-1:0]        shaped;
  logic signed [mpc_pkg::VOLT_W-1:0]        volt_sat;
  logic signed [mpc_pkg::BIAS_W-1:0]        biased;
  logic signed [mpc_pkg::PROD_W-1:0]        scaled;
  logic [mpc_pkg::QUO_W-1:0]                coarse;
  logic [mpc_pkg::SCALE_W-1:0]              recip_prod;
  logic [mpc_pkg::SCALE_W-mpc_pkg::RECIP_SHIFT-1:0] quo;

  assign sum_rnd = sum + mpc_pkg::SUM_W'(2 ** (mpc_pkg::COEF_FRAC - 1));
  assign u_neg   = u_r[mpc_pkg::ROUND_W-1];
  assign u_mag   = u_neg ? mpc_pkg::ROUND_W'(-u_r) : mpc_pkg::ROUND_W'(u_r);
  assign u_low   = u_r[mpc_pkg::BIAS_W-1:0];

  always_comb begin
    if (u_mag > mpc_pkg::ROUND_W'(cfg.drive_limit)) begin
      shaped = u_neg ? -mpc_pkg::BIAS_W'(cfg.drive_limit) : mpc_pkg::BIAS_W'(cfg.drive_limit);
    end else if (u_mag < mpc_pkg::ROUND_W'(cfg.dead_threshold)) begin
      shaped = u_neg ? u_low - mpc_pkg::BIAS_W'(cfg.friction_offset)
                     : u_low + mpc_pkg::BIAS_W'(cfg.friction_offset);
    end else begin
      shaped = u_low;
    end
    if (shaped > mpc_pkg::BIAS_W'(mpc_pkg::V_MAX)) begin
      volt_sat = mpc_pkg::VOLT_W'(mpc_pkg::V_MAX);
    end else if (shaped < -mpc_pkg::BIAS_W'(mpc_pkg::V_MAX)) begin
      volt_sat = -mpc_pkg::VOLT_W'(mpc_pkg::V_MAX);
    end else begin
      volt_sat = shaped[mpc_pkg::VOLT_W-1:0];
    end
  end

  assign biased = mpc_pkg::BIAS_W'(drive_voltage) + mpc_pkg::BIAS_W'(mpc_pkg::V_BIAS);
  assign coarse = (scaled <= 0) ? '0 : scaled[mpc_pkg::PROD_W-2:mpc_pkg::PWM_SHIFT];
  assign quo    = recip_prod[mpc_pkg::SCALE_W-1:mpc_pkg::RECIP_SHIFT];
  assign done   = stage_vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      stage_vld <= {stage_vld[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u_r <= sum_rnd[mpc_pkg::SUM_W-1:mpc_pkg::COEF_FRAC];
    end
    if (stage_vld[0]) begin
      drive_voltage <= volt_sat;
    end
    if (stage_vld[1]) begin
      scaled <= mpc_pkg::PROD_W'(biased) * mpc_pkg::PROD_W'($signed({1'b0, cfg.pwm_period}));
    end
    if (stage_vld[2]) begin
      recip_prod <= mpc_pkg::SCALE_W'(coarse) * mpc_pkg::SCALE_W'(mpc_pkg::RECIP);
    end
    if (stage_vld[3]) begin
      if (quo > mpc_pkg::SCALE_W'(cfg.pwm_period)) begin
        compare_value <= cfg.pwm_period;
      end else begin
        compare_value <= quo[mpc_pkg::PERIOD_W-1:0];
      end
    end
  end

endmodule

// ----- sim/motor_position_compensator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_position_compensator_test - self-checking bench for the compensator
// A short table of directed ticks and register writes is followed by random
// phases with new register settings and a mix of encoder deltas that changes
// between phases. Every result transfer is checked field by field against
// table values or an in-bench model of the angle accumulator, difference
// equation, clamp with friction offset and PWM mapping. Both sides of the
// stream idle at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module motor_position_compensator_test;
  import mpc_pkg::*;

  localparam longint GAIN_E0 = 60767076;
  localparam longint GAIN_E1 = -82476794;
  localparam longint GAIN_E2 = 49727668;
  localparam longint GAIN_E3 = 11235702;
  localparam longint GAIN_U1 = 129940 + 10179;
  localparam longint GAIN_U2 = -249477;
  localparam longint GAIN_U3 = -9805;
  localparam int GAIN_FRAC = 24;
  localparam longint VOLT_MAX = 1048575;
  localparam longint ERR_MAX = 64'sd2147483647;
  localparam longint ERR_MIN = -64'sd2147483648;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;

  localparam int PHASES = 14;
  localparam int TICKS_PER_PHASE = 125;
  localparam int LONG_HOLD = 600;
  localparam int HOLD_AFTER = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int LIMIT_CYCLES = 1000000;

  typedef enum int {MIX_UNIFORM, MIX_TRACKING, MIX_DRIFT, MIX_HOMING} tick_mix_t;
  typedef enum int {SET_HIGH, SET_LOW, SET_NOMINAL, SET_RANDOM} set_kind_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

  typedef struct packed {
    logic [15:0]        compare_value;
    logic signed [20:0] drive_voltage;
    logic signed [31:0] angle_now;
    logic signed [31:0] angle_error;
  } tick_result_t;

  typedef struct packed {
    logic                 is_write;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [31:0]          reg_value;
    logic signed [15:0]   count_delta;
    logic                 enabled;
    logic                 known;
    tick_result_t         outcome;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [103:0]         m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  motor_position_compensator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state and register copies
  logic signed [31:0] set_target = 32'sd5898240;
  longint set_limit = 786432;
  longint set_dead = 137626;
  longint set_friction = 117965;
  longint set_period = 8999;
  int angle_acc = 0;
  longint err_hist[3] = '{0, 0, 0};
  longint volt_hist[3] = '{0, 0, 0};

  tick_result_t pending_results[$];
  plan_row_t plan[$];
  tick_result_t oldest;
  int mismatches = 0;
  int results_taken = 0;
  int ticks_sent = 0;
  int writes_done = 0;
  int angle_wraps = 0;
  int error_sats = 0;
  int clamps = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int rx_left = 0;
  bit long_hold_done = 1'b0;
  rx_pattern_t rx_mode = RX_OPEN;

  function automatic tick_result_t predict_tick(input logic signed [15:0] cnt, input logic en);
    tick_result_t r;
    longint num, step, wide, err, acc, volt, mag, cmp;
    num = -(longint'(cnt) <<< FRAC_BITS);
    if (num >= 0) begin
      step = (num + STEP_BIAS) / STEP_DIVISOR;
    end else begin
      step = -((-num + STEP_BIAS) / STEP_DIVISOR);
    end
    wide = longint'(angle_acc) + step;
    if (wide > ERR_MAX || wide < ERR_MIN) begin
      angle_wraps++;
    end
    angle_acc = int'(wide);
    err = (en ? longint'(set_target) : 64'sd0) - longint'(angle_acc);
    if (err > ERR_MAX || err < ERR_MIN) begin
      error_sats++;
      err = (err > ERR_MAX) ? ERR_MAX : ERR_MIN;
    end
    if (en) begin
      acc = GAIN_E0 * err + GAIN_E1 * err_hist[0] + GAIN_E2 * err_hist[1]
          + GAIN_E3 * err_hist[2] + GAIN_U1 * volt_hist[0] + GAIN_U2 * volt_hist[1]
          + GAIN_U3 * volt_hist[2];
    end else begin
      acc = GAIN_E0 * err;
    end
    volt = (acc + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    mag = (volt < 0) ? -volt : volt;
    if (mag > set_limit) begin
      clamps++;
      volt = (volt < 0) ? -set_limit : set_limit;
    end else if (mag < set_dead) begin
      volt = (volt < 0) ? volt - set_friction : volt + set_friction;
    end
    if (volt > VOLT_MAX) begin
      volt = VOLT_MAX;
    end else if (volt < -VOLT_MAX) begin
      volt = -VOLT_MAX;
    end
    if (en) begin
      err_hist[2] = err_hist[1];
      err_hist[1] = err_hist[0];
      volt_hist[2] = volt_hist[1];
      volt_hist[1] = volt_hist[0];
    end else begin
      err_hist[2] = 0;
      err_hist[1] = 0;
      volt_hist[2] = 0;
      volt_hist[1] = 0;
    end
    err_hist[0] = err;
    volt_hist[0] = volt;
    cmp = (volt + (64'sd12 <<< FRAC_BITS)) * set_period;
    if (cmp <= 0) begin
      cmp = 0;
    end else begin
      cmp = cmp / (64'sd24 <<< FRAC_BITS);
    end
    if (cmp > set_period) begin
      cmp = set_period;
    end
    r.compare_value = cmp[15:0];
    r.drive_voltage = volt[20:0];
    r.angle_now = angle_acc;
    r.angle_error = err[31:0];
    return r;
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    case (idx)
      REG_TARGET_ANGLE:    set_target = value;
      REG_DRIVE_LIMIT:     set_limit = value[LIM_W-1:0];
      REG_DEAD_THRESHOLD:  set_dead = value[LIM_W-1:0];
      REG_FRICTION_OFFSET: set_friction = value[LIM_W-1:0];
      REG_PWM_PERIOD:      set_period = value[PERIOD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic plan_row_t tick_row(input logic signed [15:0] cnt, input logic en);
    plan_row_t r;
    r = '0;
    r.count_delta = cnt;
    r.enabled = en;
    return r;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_index = idx;
    r.reg_value = value;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic signed [15:0] cnt, input logic en,
                                          input logic [15:0] cmp, input logic signed [20:0] volt,
                                          input logic signed [31:0] ang,
                                          input logic signed [31:0] err);
    plan_row_t r;
    r = tick_row(cnt, en);
    r.known = 1'b1;
    r.outcome.compare_value = cmp;
    r.outcome.drive_voltage = volt;
    r.outcome.angle_now = ang;
    r.outcome.angle_error = err;
    return r;
  endfunction

  function automatic plan_row_t random_tick(input tick_mix_t mix);
    logic signed [15:0] cnt;
    logic en;
    case (mix)
      MIX_UNIFORM: begin
        cnt = 16'($urandom);
        en = 1'($urandom);
      end
      MIX_TRACKING: begin
        cnt = 16'($urandom_range(0, 400)) - 16'sd200;
        en = ($urandom_range(0, 15) != 0);
      end
      MIX_DRIFT: begin
        cnt = -16'($urandom_range(30000, 32768));
        en = ($urandom_range(0, 7) != 0);
      end
      default: begin
        cnt = 16'($urandom_range(0, 2000)) - 16'sd1000;
        en = ($urandom_range(0, 3) == 0);
      end
    endcase
    return tick_row(cnt, en);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_setting(idx, value);
    writes_done++;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic offer_tick(input plan_row_t row);
    tick_result_t predicted;
    s_tdata <= row.count_delta;
    s_tuser <= row.enabled;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_tick(row.count_delta, row.enabled);
    pending_results.push_back(row.known ? row.outcome : predicted);
    ticks_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_taken++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no tick outstanding");
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("compare_value", oldest.compare_value, m_tdata[15:0]);
        check_field("drive_voltage", oldest.drive_voltage, $signed(m_tdata[36:16]));
        check_field("angle_now", oldest.angle_now, $signed(m_tdata[68:37]));
        check_field("angle_error", oldest.angle_error, $signed(m_tdata[100:69]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!long_hold_done && results_taken >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_pattern_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 300);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom);
        RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
        default:   m_tready <= ~m_tready;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int burst;
    int directed_ticks;
    set_kind_t kind;
    logic [31:0] tgt, lim, dz, fr, per;

    plan.push_back(known_row(16'sd0, 1'b0, 16'd5174, 21'sd117965, 32'sd0, 32'sd0));
    plan.push_back(known_row(16'sd0, 1'b0, 16'd5174, 21'sd117965, 32'sd0, 32'sd0));
    plan.push_back(tick_row(16'sd0, 1'b1));
    plan.push_back(tick_row(16'sd32767, 1'b1));
    plan.push_back(tick_row(-16'sd32768, 1'b1));
    plan.push_back(tick_row(16'sd1, 1'b0));
    plan.push_back(tick_row(-16'sd1, 1'b1));
    plan.push_back(write_row(REG_TARGET_ANGLE, 32'h7FFF_FFFF));
    plan.push_back(tick_row(16'sd32767, 1'b1));
    plan.push_back(write_row(REG_TARGET_ANGLE, 32'h8000_0000));
    plan.push_back(tick_row(-16'sd32768, 1'b1));
    plan.push_back(tick_row(-16'sd32768, 1'b1));
    plan.push_back(write_row(REG_DRIVE_LIMIT, 32'h0000_0000));
    plan.push_back(tick_row(-16'sd200, 1'b1));
    plan.push_back(tick_row(16'sd0, 1'b0));
    plan.push_back(write_row(REG_DRIVE_LIMIT, 32'hFFFF_FFFF));
    plan.push_back(write_row(REG_DEAD_THRESHOLD, 32'hFFFF_FFFF));
    plan.push_back(write_row(REG_FRICTION_OFFSET, 32'hFFFF_FFFF));
    plan.push_back(tick_row(16'sd100, 1'b1));
    plan.push_back(tick_row(-16'sd100, 1'b0));
    plan.push_back(write_row(REG_PWM_PERIOD, 32'h0000_0000));
    plan.push_back(tick_row(16'sd5, 1'b1));
    plan.push_back(write_row(REG_PWM_PERIOD, 32'hFFFF_FFFF));
    plan.push_back(write_row(REG_TARGET_ANGLE, 32'h0000_0000));
    plan.push_back(write_row(REG_SPARE_FIRST, 32'hFFFF_FFFF));
    plan.push_back(write_row(REG_SPARE_LAST, 32'h0000_0001));
    plan.push_back(tick_row(16'sd12, 1'b1));
    plan.push_back(tick_row(-16'sd12, 1'b0));
    plan.push_back(write_row(REG_FRICTION_OFFSET, 32'h0000_0000));
    plan.push_back(write_row(REG_DEAD_THRESHOLD, 32'h0000_0000));
    plan.push_back(tick_row(-16'sd32768, 1'b0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_idle();
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        offer_tick(plan[i]);
        pause_sender($urandom_range(0, 3));
      end
    end
    directed_ticks = ticks_sent;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      kind = (p % 5 < 3) ? set_kind_t'(p % 5) : SET_RANDOM;
      case (kind)
        SET_HIGH: begin
          lim = 32'h000F_FFFF;
          dz = 32'h000F_FFFF;
          fr = 32'h000F_FFFF;
          per = 32'h0000_FFFF;
        end
        SET_LOW: begin
          lim = 32'h0;
          dz = 32'h0;
          fr = 32'h0;
          per = 32'h1;
        end
        SET_NOMINAL: begin
          lim = 32'd786432;
          dz = 32'd137626;
          fr = 32'd117965;
          per = 32'd8999;
        end
        default: begin
          lim = $urandom;
          dz = $urandom;
          fr = $urandom;
          per = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 65535);
        end
      endcase
      tgt = (p % 2 != 0) ? $urandom : $urandom_range(0, 47185920) - 23592960;
      write_reg(REG_TARGET_ANGLE, tgt);
      write_reg(REG_DRIVE_LIMIT, lim);
      write_reg(REG_DEAD_THRESHOLD, dz);
      write_reg(REG_FRICTION_OFFSET, fr);
      write_reg(REG_PWM_PERIOD, per);
      if (p % 4 == 3) begin
        write_reg(REG_SPARE_LAST, $urandom);
      end
      burst = 0;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          if (p % 3 != 0) begin
            pause_sender($urandom_range(1, 12));
          end
        end
        burst--;
        offer_tick(random_tick(tick_mix_t'(p % 4)));
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d ticks (%0d directed) around %0d register writes; %0d results checked.",
             ticks_sent, directed_ticks, writes_done, results_taken);
    $display("Angle wrapped %0d times, error saturated %0d times, drive clamped %0d times.",
             angle_wraps, error_sats, clamps);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
